// ===== sv/bitmask_code_decompressor_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor assertion macros
// Concurrent check wrappers; empty when compiled for synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMASK_CODE_DECOMPRESSOR_ASSERT_SVH
`define BITMASK_CODE_DECOMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define BMDC_ASSERT_ALWAYS(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define BMDC_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define BMDC_ASSERT_ALWAYS(lbl, ck, rn, expr, msg)
`define BMDC_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== sv/bmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor package
// Item types, codeword formats, queue records and shared constants.
// ----------------------------------------------------------------------------
package bmdc_pkg;

	localparam int WORD_W      = 32;
	localparam int NUM_DICT    = 8;
	localparam int IDX_W       = $clog2(NUM_DICT);
	localparam int LEFT_MAX    = 34;              // longest unfinished codeword
	localparam int POOL_W      = LEFT_MAX + WORD_W;
	localparam int CNT_W       = $clog2(POOL_W + 1);
	localparam int FMT_W       = 3;
	localparam int LEN_W       = 6;
	localparam int QUEUE_DEPTH = 4;

	// codeword formats
	localparam logic [FMT_W-1:0] FMT_REP  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_MASK = 3'd1;
	localparam logic [FMT_W-1:0] FMT_ONE  = 3'd2;
	localparam logic [FMT_W-1:0] FMT_ADJ  = 3'd3;
	localparam logic [FMT_W-1:0] FMT_TWO  = 3'd4;
	localparam logic [FMT_W-1:0] FMT_DICT = 3'd5;
	localparam logic [FMT_W-1:0] FMT_LIT  = 3'd6;
	localparam logic [FMT_W-1:0] FMT_END  = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] compressed_word;
		logic              restart;
	} code_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] instruction;
		logic              last;
	} insn_item_t;

	typedef logic [NUM_DICT-1:0][WORD_W-1:0] dict_t;

	// value source: format and the 32 stream bits after its header
	typedef struct packed {
		logic [FMT_W-1:0]  fmt;
		logic [WORD_W-1:0] body;
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [1:0] reps;   // extra copies of the value
	} rec_t;

	typedef struct packed {
		rec_t rec;
		logic last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic parsing;
		logic held_valid;
	} fr_stat_t;

	// codeword length including the header
	function automatic logic [LEN_W-1:0] code_len(input logic [FMT_W-1:0] fmt);
		logic [LEN_W-1:0] len;
		case (fmt)
			FMT_REP:  len = 6'd5;
			FMT_MASK: len = 6'd15;
			FMT_ONE:  len = 6'd11;
			FMT_ADJ:  len = 6'd11;
			FMT_TWO:  len = 6'd16;
			FMT_DICT: len = 6'd6;
			FMT_LIT:  len = 6'd35;
			default:  len = 6'd3;
		endcase
		return len;
	endfunction

endpackage

// ===== sv/bmdc_front.sv =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor front end
// Takes stream words, splits the bit pool into codewords one per cycle when
// the queue has room, queues one record each and marks each word's last.
// ----------------------------------------------------------------------------
module bmdc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                code_valid,
	input  bmdc_pkg::code_item_t code_item,
	input  bmdc_pkg::q_stat_t    q_stat,
	output logic                q_push,
	output bmdc_pkg::entry_t     q_entry,
	output bmdc_pkg::fr_stat_t   fr_stat
);
	import bmdc_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PARSE = 1'b1;

	logic             state_q;
	logic [POOL_W-1:0] pool_q;      // left-aligned, unused bits zero
	logic [CNT_W-1:0]  cnt_q;
	logic             end_q;
	logic             prev_zero_q; // no instruction since reset or restart
	rec_t             held_q;
	logic             held_valid_q;

	logic [FMT_W-1:0] fmt;
	logic [LEN_W-1:0] need;
	logic             have3, is_end, complete, advance, accept;
	logic [POOL_W-1:0] pool_base, pool_merged;
	logic [CNT_W-1:0]  cnt_base;
	logic             end_base;
	rec_t             new_rec;
	src_t             src_reset;

	assign src_reset = '{fmt: FMT_LIT, body: '0};

	// classify the codeword at the head of the pool
	assign fmt      = pool_q[POOL_W-1 -: FMT_W];
	assign need     = code_len(fmt);
	assign have3    = cnt_q >= CNT_W'(FMT_W);
	assign is_end   = have3 && (fmt == FMT_END);
	assign complete = have3 && (fmt != FMT_END) && (cnt_q >= CNT_W'(need));

	// a held record leaves whenever the parse moves on
	assign advance = (state_q == ST_PARSE) && (!held_valid_q || !q_stat.full);
	assign q_push  = (state_q == ST_PARSE) && held_valid_q && !q_stat.full;
	assign q_entry = '{rec: held_q, last: !complete};

	// build the next record; a repeat reuses the expander's last value, or
	// zero when nothing has been issued since reset or restart
	always_comb begin
		if (fmt == FMT_REP) begin
			new_rec.src  = prev_zero_q ? src_reset : '{fmt: FMT_REP, body: '0};
			new_rec.reps = pool_q[POOL_W-FMT_W-1 -: 2];
		end else begin
			new_rec.src  = '{fmt: fmt, body: pool_q[POOL_W-FMT_W-1 -: WORD_W]};
			new_rec.reps = 2'd0;
		end
	end

	// merge a new word behind the leftover bits
	assign accept      = (state_q == ST_IDLE) && code_valid;
	assign end_base    = code_item.restart ? 1'b0 : end_q;
	assign pool_base   = code_item.restart ? '0 : pool_q;
	assign cnt_base    = code_item.restart ? '0 : cnt_q;
	assign pool_merged = pool_base |
		({code_item.compressed_word, {LEFT_MAX{1'b0}}} >> cnt_base);

	assign fr_stat = '{parsing: (state_q == ST_PARSE), held_valid: held_valid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_q       <= '0;
			cnt_q        <= '0;
			end_q        <= 1'b0;
			prev_zero_q  <= 1'b1;
			held_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_q <= end_base;
						if (code_item.restart) begin
							prev_zero_q <= 1'b1;
						end
						if (!end_base) begin
							pool_q  <= pool_merged;
							cnt_q   <= cnt_base + CNT_W'(WORD_W);
							state_q <= ST_PARSE;
						end
					end
				end
				ST_PARSE: begin
					if (advance) begin
						if (complete) begin
							held_valid_q <= 1'b1;
							pool_q       <= pool_q << need;
							cnt_q        <= cnt_q - CNT_W'(need);
							if (fmt != FMT_REP) begin
								prev_zero_q <= 1'b0;
							end
						end else begin
							held_valid_q <= 1'b0;
							state_q      <= ST_IDLE;
							// drop padding and leftover after the end mark
							if (is_end) begin
								end_q  <= 1'b1;
								pool_q <= '0;
								cnt_q  <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the latest codeword until its successor is known
	always_ff @(posedge clk) begin
		if (advance && complete) begin
			held_q <= new_rec;
		end
	end

endmodule

// ===== sv/bmdc_queue.sv =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor record queue
// Small register queue between the front end and the expander.
// ----------------------------------------------------------------------------
module bmdc_queue #(
	parameter int DEPTH = bmdc_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bmdc_pkg::entry_t   wr_entry,
	input  logic              pop,
	output bmdc_pkg::entry_t   rd_entry,
	output bmdc_pkg::q_stat_t  stat
);
	import bmdc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int QCNT_W = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat     = '{full: (count_q == QCNT_W'(DEPTH)), empty: (count_q == '0)};
	assign rd_entry = mem_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the record
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== sv/bmdc_back.sv =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor expander
// Expands queued records against the dictionary into the output register,
// one instruction per cycle unless stalled, repeating as a record asks.
// ----------------------------------------------------------------------------
module bmdc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bmdc_pkg::dict_t      dict,
	input  bmdc_pkg::entry_t     head,
	input  bmdc_pkg::q_stat_t    q_stat,
	output logic                q_pop,
	output logic                insn_valid,
	input  logic                insn_ready,
	output bmdc_pkg::insn_item_t insn_item
);
	import bmdc_pkg::*;

	logic [1:0]        rep_q;
	logic              out_valid_q;
	insn_item_t        out_q;
	logic [WORD_W-1:0] last_val_q;
	logic [WORD_W-1:0] value;
	logic              load, fire, done;

	// expand one value source against the dictionary
	function automatic logic [WORD_W-1:0] expand(input src_t s, input dict_t d);
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] v;
		b = s.body;
		case (s.fmt)
			FMT_MASK: v = d[b[22:20]] ^ ({b[26:23], 28'd0} >> b[31:27]);
			FMT_ONE:  v = d[b[26:24]] ^ (32'h8000_0000 >> b[31:27]);
			FMT_ADJ:  v = d[b[26:24]] ^ (32'hC000_0000 >> b[31:27]);
			FMT_TWO:  v = d[b[21:19]] ^ (32'h8000_0000 >> b[31:27])
				^ ((32'h8000_0000 >> b[26:22]) & ~(32'h8000_0000 >> b[31:27]));
			FMT_DICT: v = d[b[31:29]];
			default:  v = b;
		endcase
		return v;
	endfunction

	// a repeat record reissues the last instruction put into the output register
	assign value = (head.rec.src.fmt == FMT_REP) ? last_val_q : expand(head.rec.src, dict);
	assign load  = !out_valid_q || insn_ready;
	assign fire  = load && !q_stat.empty;
	assign done  = rep_q == head.rec.reps;
	assign q_pop = fire && done;

	assign insn_valid = out_valid_q;
	assign insn_item  = out_q;

	// count copies and fill the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q       <= '0;
			out_valid_q <= 1'b0;
			last_val_q  <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !q_stat.empty;
			end
			if (fire) begin
				rep_q      <= done ? 2'd0 : rep_q + 1'b1;
				last_val_q <= value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= '{instruction: value, last: head.last && done};
		end
	end

endmodule

// ===== sv/bitmask_code_decompressor.sv =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor
// Expands a bitmask dictionary compressed code stream into 32-bit
// instructions.
// ----------------------------------------------------------------------------
// A compressed word is taken when the front end is idle; the front end then
// peels one codeword per cycle off a 66-bit bit pool while the queue has
// room, and closes the word before it returns to idle for the next one.
// Records wait in a short queue while the expander issues one instruction
// per cycle unless the receiver stalls (a repeat codeword gives up to four),
// so the front-end parse loop sets the input rate and the expander sets the
// output rate. The user must write dictionary registers through the plain
// write port only while the block is idle; the block does not enforce this.
module bitmask_code_decompressor #(
	parameter int QUEUE_DEPTH = bmdc_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              code_valid,
	output logic                              code_ready,
	input  bmdc_pkg::code_item_t               code_item,
	output logic                              insn_valid,
	input  logic                              insn_ready,
	output bmdc_pkg::insn_item_t               insn_item,
	input  logic                              cfg_we,
	input  logic [bmdc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [bmdc_pkg::WORD_W-1:0]        cfg_data
);
	import bmdc_pkg::*;

`include "bitmask_code_decompressor_assert.svh"

	dict_t    dict_q;
	logic     q_push, q_pop;
	entry_t   q_wr_entry, q_rd_entry;
	q_stat_t  q_stat;
	fr_stat_t fr_stat;

	// dictionary registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_q <= '0;
		end else if (cfg_we) begin
			dict_q[cfg_index] <= cfg_data;
		end
	end

	assign code_ready = !fr_stat.parsing;

	bmdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_item  (code_item),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_entry    (q_wr_entry),
		.fr_stat    (fr_stat)
	);

	bmdc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.stat     (q_stat)
	);

	bmdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dict       (dict_q),
		.head       (q_rd_entry),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.insn_valid (insn_valid),
		.insn_ready (insn_ready),
		.insn_item  (insn_item)
	);

	// checks on front, queue and expander cooperation
	`BMDC_ASSERT_IMPLY(a_push_room, clk, arst_n, q_push, !q_stat.full, "push into full queue")
	`BMDC_ASSERT_IMPLY(a_pop_item, clk, arst_n, q_pop, !q_stat.empty, "pop from empty queue")
	`BMDC_ASSERT_IMPLY(a_idle_clean, clk, arst_n, code_ready, !fr_stat.held_valid, "record held while idle")
	`BMDC_ASSERT_ALWAYS(a_no_push_idle, clk, arst_n, !(q_push && code_ready), "push while idle")

endmodule

// ===== verif/bitmask_code_decompressor_tb.sv =====
// ----------------------------------------------------------------------------
// Bitmask code decompressor testbench
// Drives compressed stream words through the valid/ready input channel,
// predicts every expanded instruction from a local copy of the decoder
// state and dictionary, and checks each instruction and its last flag in
// order. Well-formed streams with random codewords make up most of the
// traffic; random noise words, restarts and words after an end mark fill
// the rest. The dictionary is reloaded between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module bitmask_code_decompressor_tb;
	import bmdc_pkg::*;

	localparam int unsigned WORD_TARGET   = 480;
	localparam int unsigned CFG_STRIDE    = 120;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned QUIET_LIMIT   = 4000;

	typedef enum int {DICT_MIXED, DICT_RANDOM, DICT_ONES, DICT_ZEROS} dict_fill_e;

	// expected instruction store and decoder prediction
	class decomp_scoreboard;
		logic [WORD_W-1:0]   dict_words [NUM_DICT];
		logic [LEFT_MAX-1:0] carry_bits;
		int unsigned         carry_count;
		logic [WORD_W-1:0]   prev_insn;
		bit                  end_mark;
		bit                  pool_bits [POOL_W];
		insn_item_t          pending_insns [$];
		int unsigned         words_used;
		int unsigned         words_ignored;
		int unsigned         insns_checked;
		int unsigned         fails;
		int unsigned         fmt_count [8];

		function new();
			foreach (dict_words[i]) dict_words[i] = '0;
			foreach (fmt_count[i]) fmt_count[i] = 0;
			carry_bits = '0;
			carry_count = 0;
			prev_insn = '0;
			end_mark = 1'b0;
			words_used = 0;
			words_ignored = 0;
			insns_checked = 0;
			fails = 0;
		endfunction

		// codeword length, header included
		static function int unsigned code_bits(logic [FMT_W-1:0] fmt);
			case (fmt)
				FMT_REP:  return 5;
				FMT_MASK: return 15;
				FMT_ONE:  return 11;
				FMT_ADJ:  return 11;
				FMT_TWO:  return 16;
				FMT_DICT: return 6;
				FMT_LIT:  return 35;
				default:  return 3;
			endcase
		endfunction

		// read width bits of the pool from start, first bit as MSB
		function logic [39:0] take_bits(int unsigned start, int unsigned width);
			logic [39:0] v = '0;
			for (int unsigned i = 0; i < width; i++) begin
				v = {v[38:0], (start + i < POOL_W) ? pool_bits[start + i] : 1'b0};
			end
			return v;
		endfunction

		// expand one accepted stream word into its expected instructions
		function void note_word(code_item_t item);
			int unsigned n;
			int unsigned pos;
			int unsigned need;
			int unsigned reps;
			int unsigned produced;
			logic [FMT_W-1:0]  fmt;
			logic [4:0]        loc;
			logic [4:0]        loc2;
			logic [IDX_W-1:0]  idx;
			logic [WORD_W-1:0] val;
			logic [WORD_W-1:0] mask_bits;
			insn_item_t        e;
			if (item.restart) begin
				carry_bits = '0;
				carry_count = 0;
				prev_insn = '0;
				end_mark = 1'b0;
			end
			// drop words after an end mark
			if (end_mark) begin
				words_ignored++;
				return;
			end
			words_used++;
			n = 0;
			pos = 0;
			produced = 0;
			for (int unsigned i = 0; i < carry_count; i++) begin
				pool_bits[n] = carry_bits[carry_count - 1 - i];
				n++;
			end
			for (int i = WORD_W - 1; i >= 0; i--) begin
				pool_bits[n] = item.compressed_word[i];
				n++;
			end
			while (n - pos >= FMT_W) begin
				fmt = FMT_W'(take_bits(pos, FMT_W));
				need = code_bits(fmt);
				if (fmt == FMT_END) begin
					fmt_count[fmt]++;
					end_mark = 1'b1;
					break;
				end
				// hold an unfinished codeword for the next word
				if (n - pos < need)
					break;
				fmt_count[fmt]++;
				reps = 1;
				case (fmt)
					FMT_REP: begin
						reps = 32'(take_bits(pos + 3, 2)) + 1;
						val = prev_insn;
					end
					FMT_MASK: begin
						loc = 5'(take_bits(pos + 3, 5));
						mask_bits = {4'(take_bits(pos + 8, 4)), 28'd0};
						idx = IDX_W'(take_bits(pos + 12, 3));
						val = dict_words[idx] ^ (mask_bits >> loc);
					end
					FMT_ONE: begin
						loc = 5'(take_bits(pos + 3, 5));
						idx = IDX_W'(take_bits(pos + 8, 3));
						val = dict_words[idx] ^ (32'h8000_0000 >> loc);
					end
					FMT_ADJ: begin
						loc = 5'(take_bits(pos + 3, 5));
						idx = IDX_W'(take_bits(pos + 8, 3));
						val = dict_words[idx] ^ (32'hC000_0000 >> loc);
					end
					FMT_TWO: begin
						loc2 = 5'(take_bits(pos + 3, 5));
						loc = 5'(take_bits(pos + 8, 5));
						idx = IDX_W'(take_bits(pos + 13, 3));
						val = dict_words[idx] ^
							((32'h8000_0000 >> loc) | (32'h8000_0000 >> loc2));
					end
					FMT_DICT: begin
						idx = IDX_W'(take_bits(pos + 3, 3));
						val = dict_words[idx];
					end
					default: begin
						val = WORD_W'(take_bits(pos + 3, 32));
					end
				endcase
				for (int unsigned r = 0; r < reps; r++) begin
					e.instruction = val;
					e.last = 1'b0;
					pending_insns.push_back(e);
				end
				produced += reps;
				prev_insn = val;
				pos += need;
			end
			if (end_mark) begin
				carry_bits = '0;
				carry_count = 0;
			end else begin
				carry_count = n - pos;
				carry_bits = LEFT_MAX'(take_bits(pos, carry_count));
			end
			if (produced > 0)
				pending_insns[pending_insns.size() - 1].last = 1'b1;
		endfunction

		// compare one accepted instruction with the oldest expectation
		function void check_insn(insn_item_t got);
			insn_item_t want;
			if (pending_insns.size() == 0) begin
				$error("unexpected instruction %08h with last %0b", got.instruction, got.last);
				fails++;
				return;
			end
			want = pending_insns.pop_front();
			insns_checked++;
			if (got.instruction !== want.instruction) begin
				$error("instruction: expected %08h, actual %08h",
					want.instruction, got.instruction);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				fails++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                code_valid = 1'b0;
	logic                code_ready;
	code_item_t          code_item = '0;
	logic                insn_valid;
	logic                insn_ready = 1'b0;
	insn_item_t          insn_item;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [WORD_W-1:0]   cfg_data = '0;

	decomp_scoreboard sb = new();

	bit          stream_q [$];
	bit          restart_next = 1'b1;
	int          burst_left = 0;
	logic [15:0] ready_tick = '0;
	int          ready_mode = 0;
	int unsigned quiet_cycles = 0;

	bitmask_code_decompressor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_item  (code_item),
		.insn_valid (insn_valid),
		.insn_ready (insn_ready),
		.insn_item  (insn_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (code_valid && code_ready)
				sb.note_word(code_item);
			if (insn_valid && insn_ready)
				sb.check_insn(insn_item);
		end
	end

	// receiver stalls: switch between four ready patterns
	always @(posedge clk) begin
		ready_tick <= ready_tick + 16'd1;
		if (ready_tick % 97 == 0)
			ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0:       insn_ready <= 1'b1;
			1:       insn_ready <= 1'($urandom_range(0, 1));
			2:       insn_ready <= (ready_tick[3:0] < 4'd5);
			default: insn_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// end the run when no item moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((code_valid && code_ready) || (insn_valid && insn_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// offer one word; the sender may idle between bursts of random length
	task automatic send_word(logic [WORD_W-1:0] w, bit rs);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				code_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		code_valid <= 1'b1;
		code_item <= {w, rs};
		@(posedge clk);
		while (!code_ready) @(posedge clk);
	endtask

	task automatic hold_idle(int unsigned cycles);
		code_valid <= 1'b0;
		burst_left = 0;
		repeat (cycles) @(posedge clk);
	endtask

	// pause until every expected instruction is out, then let the block settle
	task automatic drain();
		hold_idle(1);
		while (sb.pending_insns.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_dictionary(dict_fill_e fill);
		logic [WORD_W-1:0] val;
		drain();
		for (int i = 0; i < NUM_DICT; i++) begin
			case (fill)
				DICT_MIXED:  val = (i == 2) ? 32'h8000_0001 : (i == 5) ? 32'h7FFF_FFFE
					: i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
				DICT_RANDOM: val = $urandom();
				DICT_ONES:   val = '1;
				default:     val = '0;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= i[IDX_W-1:0];
			cfg_data <= val;
			sb.dict_words[i] = val;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic push_bits(logic [34:0] v, int unsigned width);
		for (int i = width - 1; i >= 0; i--)
			stream_q.push_back(v[i]);
	endtask

	// append a codeword; its fields sit left-aligned in body
	task automatic push_code(logic [FMT_W-1:0] fmt, logic [WORD_W-1:0] body);
		int unsigned n;
		n = decomp_scoreboard::code_bits(fmt) - FMT_W;
		push_bits(35'(fmt), FMT_W);
		for (int unsigned i = 0; i < n; i++)
			stream_q.push_back(body[WORD_W - 1 - i]);
	endtask

	task automatic send_full_words();
		logic [WORD_W-1:0] w;
		while (stream_q.size() >= WORD_W) begin
			for (int i = 0; i < WORD_W; i++)
				w = {w[WORD_W-2:0], stream_q.pop_front()};
			send_word(w, restart_next);
			restart_next = 1'b0;
		end
	endtask

	// end mark, random padding to the word boundary; the next stream restarts
	task automatic close_stream();
		push_code(FMT_END, '0);
		while (stream_q.size() % WORD_W != 0)
			stream_q.push_back(1'($urandom_range(0, 1)));
		send_full_words();
		restart_next = 1'b1;
	endtask

	function automatic logic [WORD_W-1:0] random_body(logic [FMT_W-1:0] fmt);
		logic [WORD_W-1:0] b = $urandom();
		if (fmt == FMT_LIT) begin
			case ($urandom_range(0, 7))
				0:       b = '0;
				1:       b = '1;
				default: ;
			endcase
		end else begin
			// favour the first and last bit positions
			if ($urandom_range(0, 3) == 0)
				b[31:27] = $urandom_range(0, 1) ? 5'd31 : 5'd0;
			if (fmt == FMT_TWO && $urandom_range(0, 5) == 0)
				b[26:22] = b[31:27];
		end
		return b;
	endfunction

	task automatic random_stream();
		logic [FMT_W-1:0] fmt;
		repeat ($urandom_range(1, 24)) begin
			fmt = FMT_W'($urandom_range(0, 6));
			push_code(fmt, random_body(fmt));
			send_full_words();
		end
		if ($urandom_range(0, 9) < 7) begin
			close_stream();
			// words after the end mark without restart
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) send_word($urandom(), 1'b0);
		end
	endtask

	// raw words with occasional restarts, then resynchronise
	task automatic noise_words();
		repeat ($urandom_range(1, 4))
			send_word($urandom(), $urandom_range(0, 5) == 0);
		stream_q.delete();
		restart_next = 1'b1;
	endtask

	initial begin
		dict_fill_e  fill_plan [3];
		int unsigned phase;
		int unsigned next_cfg;
		fill_plan = '{DICT_RANDOM, DICT_ONES, DICT_ZEROS};
		phase = 0;
		next_cfg = CFG_STRIDE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// repeat before any instruction gives zeros
		push_code(FMT_REP, {2'd3, 30'd0});
		push_code(FMT_DICT, {3'd5, 29'd0});
		close_stream();
		load_dictionary(DICT_MIXED);

		// field extremes, mask bits past the end, same bit twice
		push_code(FMT_MASK, {5'd0, 4'hF, 3'd0, 20'd0});
		push_code(FMT_MASK, {5'd31, 4'hF, 3'd1, 20'd0});
		push_code(FMT_MASK, {5'd29, 4'h9, 3'd2, 20'd0});
		push_code(FMT_ONE, {5'd0, 3'd3, 24'd0});
		push_code(FMT_ONE, {5'd31, 3'd7, 24'd0});
		push_code(FMT_ADJ, {5'd31, 3'd1, 24'd0});
		push_code(FMT_ADJ, {5'd0, 3'd0, 24'd0});
		push_code(FMT_TWO, {5'd17, 5'd17, 3'd4, 19'd0});
		push_code(FMT_TWO, {5'd0, 5'd31, 3'd6, 19'd0});
		push_code(FMT_DICT, {3'd7, 29'd0});
		push_code(FMT_DICT, {3'd0, 29'd0});
		push_code(FMT_LIT, 32'hFFFF_FFFF);
		push_code(FMT_LIT, 32'h0000_0000);
		push_code(FMT_REP, {2'd0, 30'd0});
		close_stream();
		// ignored until restart
		send_word(32'hFFFF_FFFF, 1'b0);

		// random streams, dictionary reloaded between phases
		while (sb.words_used < WORD_TARGET) begin
			if (sb.words_used >= next_cfg && phase < 3) begin
				load_dictionary(fill_plan[phase]);
				phase++;
				next_cfg += CFG_STRIDE;
			end
			if ($urandom_range(0, 9) == 0)
				noise_words();
			else
				random_stream();
		end

		hold_idle(1);
		while (sb.pending_insns.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Decoded %0d words (%0d ignored after an end mark), %0d instructions checked",
			sb.words_used, sb.words_ignored, sb.insns_checked);
		$display("Codewords rep %0d mask %0d one %0d adj %0d two %0d dict %0d lit %0d end %0d",
			sb.fmt_count[0], sb.fmt_count[1], sb.fmt_count[2], sb.fmt_count[3],
			sb.fmt_count[4], sb.fmt_count[5], sb.fmt_count[6], sb.fmt_count[7]);
		if (sb.fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/bmdc_pkg.sv
sv/bmdc_front.sv
sv/bmdc_queue.sv
sv/bmdc_back.sv
sv/bitmask_code_decompressor.sv
verif/bitmask_code_decompressor_tb.sv
